>>> rtl/core/tcc_pkg.sv
// Shared types and constants of the two-channel timestamp coincidence block.
package tcc_pkg;

  // Per-channel hit store
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Results produced by one hit before the drain pauses
  localparam int MAX_RESULTS = 8;
  localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

  // Decoupling queues
  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_PAIR = 2'd0,
    STATUS_LOST = 2'd1,
    STATUS_DROP = 2'd2
  } status_t;

  typedef struct packed {
    logic        channel;
    logic [31:0] time_tag;
    logic [31:0] event_number;
    logic [31:0] record_index;
  } hit_t;

  typedef struct packed {
    logic [31:0] time_tag;
    logic [31:0] event_number;
    logic [31:0] record_index;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] pair_time;
    logic [31:0] event_zero;
    logic [31:0] event_one;
    logic [31:0] index_zero;
    logic [31:0] index_one;
    logic        lost_channel;
    logic [31:0] drops_so_far;
    logic        last_of_run;
  } result_t;

  // Handshake between the hit queue and the matching engine
  typedef struct packed {
    logic valid;
    hit_t hit;
  } cmd_t;

endpackage

>>> rtl/core/tcc_front.sv
// Input side: accepts hits into a short queue ahead of the matching engine.
module tcc_front
  import tcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        channel,
  input  logic [31:0] time_tag,
  input  logic [31:0] event_number,
  input  logic [31:0] record_index,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  hit_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == CMD_CNT_W'(CMD_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && (count != '0);

  assign cmd.valid = (count != '0);
  assign cmd.hit   = slots[rd_ptr];

  // Store the incoming hit
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{channel: channel, time_tag: time_tag,
                         event_number: event_number, record_index: record_index};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/core/tcc_back.sv
// Matching engine: per-channel hit stores, head compare and result generation.
module tcc_back
  import tcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CMP  = 3'b100
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t             state, state_next;
  entry_t             mem0 [QUEUE_DEPTH];
  entry_t             mem1 [QUEUE_DEPTH];
  entry_t             rd0, rd1, wr_entry;
  logic [PTR_W-1:0]   head0, head1, tail0, tail1;
  logic [FILL_W-1:0]  fill0, fill1;
  logic [RUN_W-1:0]   run_n, run_n_next;
  logic [31:0]        drops, drops_next, drops_inc;
  logic               wr0, wr1, pop0, pop1;
  logic               ch_full, cmp_last, t_eq, t_lt;

  assign wr_entry = '{time_tag: cmd.hit.time_tag, event_number: cmd.hit.event_number,
                      record_index: cmd.hit.record_index};

  // Hit stores: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (wr0) mem0[tail0] <= wr_entry;
    if (wr1) mem1[tail1] <= wr_entry;
    rd0 <= mem0[head0];
    rd1 <= mem1[head1];
  end

  assign ch_full   = cmd.hit.channel ? (fill1 == FILL_W'(QUEUE_DEPTH))
                                     : (fill0 == FILL_W'(QUEUE_DEPTH));
  assign t_eq      = (rd0.time_tag == rd1.time_tag);
  assign t_lt      = (rd0.time_tag <  rd1.time_tag);
  assign drops_inc = (drops != '1) ? drops + 32'd1 : drops;

  // Admit hits, compare heads, build results
  always_comb begin
    state_next = state;
    run_n_next = run_n;
    drops_next = drops;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    wr0        = 1'b0;
    wr1        = 1'b0;
    pop0       = 1'b0;
    pop1       = 1'b0;
    cmp_last   = 1'b0;
    res        = '0;
    res.status = STATUS_PAIR;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          if (ch_full) begin
            // Drop the hit and report it
            if (!res_full) begin
              cmd_pop          = 1'b1;
              res_push         = 1'b1;
              res.status       = STATUS_DROP;
              res.pair_time    = cmd.hit.time_tag;
              res.lost_channel = cmd.hit.channel;
              res.drops_so_far = drops;
              res.last_of_run  = 1'b1;
            end
          end else begin
            cmd_pop    = 1'b1;
            wr0        = !cmd.hit.channel;
            wr1        = cmd.hit.channel;
            run_n_next = '0;
            if (cmd.hit.channel ? (fill0 != '0) : (fill1 != '0)) begin
              state_next = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!res_full) begin
          res_push = 1'b1;
          pop0     = t_eq || t_lt;
          pop1     = t_eq || !t_lt;
          if (t_eq) begin
            res.status       = STATUS_PAIR;
            res.pair_time    = rd0.time_tag;
            res.event_zero   = rd0.event_number;
            res.event_one    = rd1.event_number;
            res.index_zero   = rd0.record_index;
            res.index_one    = rd1.record_index;
            res.drops_so_far = drops;
          end else if (t_lt) begin
            res.status       = STATUS_LOST;
            res.pair_time    = rd0.time_tag;
            res.event_zero   = rd0.event_number;
            res.index_zero   = rd0.record_index;
            res.drops_so_far = drops_inc;
            drops_next       = drops_inc;
          end else begin
            res.status       = STATUS_LOST;
            res.pair_time    = rd1.time_tag;
            res.event_one    = rd1.event_number;
            res.index_one    = rd1.record_index;
            res.lost_channel = 1'b1;
            res.drops_so_far = drops_inc;
            drops_next       = drops_inc;
          end
          cmp_last = (pop0 && (fill0 == FILL_W'(1))) ||
                     (pop1 && (fill1 == FILL_W'(1))) ||
                     (run_n == RUN_W'(MAX_RESULTS - 1));
          res.last_of_run = cmp_last;
          run_n_next      = run_n + 1'b1;
          state_next      = cmp_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head0 <= '0;
      head1 <= '0;
      tail0 <= '0;
      tail1 <= '0;
      fill0 <= '0;
      fill1 <= '0;
      run_n <= '0;
      drops <= '0;
    end else begin
      state <= state_next;
      run_n <= run_n_next;
      drops <= drops_next;
      if (wr0)  tail0 <= ptr_inc(tail0);
      if (wr1)  tail1 <= ptr_inc(tail1);
      if (pop0) head0 <= ptr_inc(head0);
      if (pop1) head1 <= ptr_inc(head1);
      fill0 <= fill0 + FILL_W'(wr0) - FILL_W'(pop0);
      fill1 <= fill1 + FILL_W'(wr1) - FILL_W'(pop1);
    end
  end

endmodule

>>> rtl/core/tcc_out.sv
// Output side: result queue presented to the consumer as empty/pop.
module tcc_out
  import tcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t              slots [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign res_full = (count == RES_CNT_W'(RES_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign head     = slots[rd_ptr];

  // Store the result
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= res;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + RES_CNT_W'(do_push) - RES_CNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/core/two_channel_timestamp_coincidence.sv
// Top level of the two-channel timestamp coincidence event builder.
//
//   Side     Handshake     Transfer when     Fields
//   hits     push / full   push && !full     channel, time_tag, event_number, record_index
//   results  empty / pop   pop && !empty     status, pair_time, event_zero/one,
//                                            index_zero/one, lost_channel,
//                                            drops_so_far, last_of_run
//
// A hit dropped on a full store yields one result.
// A stored hit is written to its store; each result then needs a registered read of
// both heads (ST_READ) and a compare and pop (ST_CMP), held on a full result queue.
// A two-entry hit queue and a four-entry result queue decouple both sides, so push
// is taken while results wait. Synchronous reset empties every queue and store.
module two_channel_timestamp_coincidence
  import tcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        channel,
  input  logic [31:0] time_tag,
  input  logic [31:0] event_number,
  input  logic [31:0] record_index,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] pair_time,
  output logic [31:0] event_zero,
  output logic [31:0] event_one,
  output logic [31:0] index_zero,
  output logic [31:0] index_one,
  output logic        lost_channel,
  output logic [31:0] drops_so_far,
  output logic        last_of_run
);

  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_push;
  logic    res_full;
  result_t res;
  result_t head;

  tcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .channel      (channel),
    .time_tag     (time_tag),
    .event_number (event_number),
    .record_index (record_index),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tcc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  tcc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  // Present the oldest result
  assign status       = head.status;
  assign pair_time    = head.pair_time;
  assign event_zero   = head.event_zero;
  assign event_one    = head.event_one;
  assign index_zero   = head.index_zero;
  assign index_one    = head.index_one;
  assign lost_channel = head.lost_channel;
  assign drops_so_far = head.drops_so_far;
  assign last_of_run  = head.last_of_run;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the two-channel timestamp coincidence event builder.
module testbench
  import tcc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit CHAN_ZERO      = 1'b0;
  localparam bit CHAN_ONE       = 1'b1;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TOTAL     = 400;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // Hit tracker: mirrors both channel stores and holds the records still owed by the block
  class coincidence_tracker;
    entry_t      store [2][QUEUE_DEPTH];
    int unsigned head [2];
    int unsigned fill [2];
    logic [31:0] drops;
    result_t     owed [$];
    int          mismatches;

    function new();
      head       = '{0, 0};
      fill       = '{0, 0};
      drops      = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    // Queue or drop the hit, then pair or abandon heads while both channels hold entries
    function void accept_hit(hit_t h);
      result_t     r;
      entry_t      e0;
      entry_t      e1;
      int unsigned c;
      int          n;
      c = h.channel;
      if (fill[c] >= QUEUE_DEPTH) begin
        r              = '0;
        r.status       = STATUS_DROP;
        r.pair_time    = h.time_tag;
        r.lost_channel = h.channel;
        r.drops_so_far = drops;
        r.last_of_run  = 1'b1;
        owed.push_back(r);
        return;
      end
      store[c][(head[c] + fill[c]) % QUEUE_DEPTH].time_tag     = h.time_tag;
      store[c][(head[c] + fill[c]) % QUEUE_DEPTH].event_number = h.event_number;
      store[c][(head[c] + fill[c]) % QUEUE_DEPTH].record_index = h.record_index;
      fill[c]++;
      n = 0;
      while (fill[0] > 0 && fill[1] > 0 && n < MAX_RESULTS) begin
        e0 = store[0][head[0]];
        e1 = store[1][head[1]];
        r  = '0;
        if (e0.time_tag == e1.time_tag) begin
          r.status     = STATUS_PAIR;
          r.pair_time  = e0.time_tag;
          r.event_zero = e0.event_number;
          r.event_one  = e1.event_number;
          r.index_zero = e0.record_index;
          r.index_one  = e1.record_index;
          head[0] = (head[0] + 1) % QUEUE_DEPTH;
          head[1] = (head[1] + 1) % QUEUE_DEPTH;
          fill[0]--;
          fill[1]--;
        end else if (e0.time_tag > e1.time_tag) begin
          if (drops != '1) drops++;
          r.status       = STATUS_LOST;
          r.pair_time    = e1.time_tag;
          r.event_one    = e1.event_number;
          r.index_one    = e1.record_index;
          r.lost_channel = CHAN_ONE;
          head[1] = (head[1] + 1) % QUEUE_DEPTH;
          fill[1]--;
        end else begin
          if (drops != '1) drops++;
          r.status       = STATUS_LOST;
          r.pair_time    = e0.time_tag;
          r.event_zero   = e0.event_number;
          r.index_zero   = e0.record_index;
          r.lost_channel = CHAN_ZERO;
          head[0] = (head[0] + 1) % QUEUE_DEPTH;
          fill[0]--;
        end
        r.drops_so_far = drops;
        owed.push_back(r);
        n++;
      end
      // Mark the closing record of this hit's run
      if (n > 0) begin
        r = owed.pop_back();
        r.last_of_run = 1'b1;
        owed.push_back(r);
      end
    endfunction

    function string describe(result_t r);
      return $sformatf("st=%0d t=%h e0=%h e1=%h i0=%h i1=%h lost=%0d drops=%0d last=%0d",
                       r.status, r.pair_time, r.event_zero, r.event_one, r.index_zero,
                       r.index_one, r.lost_channel, r.drops_so_far, r.last_of_run);
    endfunction

    // Compare one transferred record with the oldest owed one
    function void check_record(result_t got);
      result_t want;
      bit      bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected record at %0t: %s", $time, describe(got));
        return;
      end
      want = owed.pop_front();
      bad  = (got.status != want.status) || (got.pair_time != want.pair_time) ||
             (got.event_zero != want.event_zero) || (got.event_one != want.event_one) ||
             (got.index_zero != want.index_zero) || (got.index_one != want.index_one) ||
             (got.lost_channel != want.lost_channel) ||
             (got.drops_so_far != want.drops_so_far) ||
             (got.last_of_run != want.last_of_run);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("record mismatch at %0t", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        push         = 1'b0;
  logic        full;
  logic        channel      = 1'b0;
  logic [31:0] time_tag     = '0;
  logic [31:0] event_number = '0;
  logic [31:0] record_index = '0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [1:0]  status;
  logic [31:0] pair_time;
  logic [31:0] event_zero;
  logic [31:0] event_one;
  logic [31:0] index_zero;
  logic [31:0] index_one;
  logic        lost_channel;
  logic [31:0] drops_so_far;
  logic        last_of_run;

  coincidence_tracker tracker;
  bit idling_on       = 1'b1;
  bit rx_hold_request = 1'b0;
  int sent            = 0;
  int quiet_cycles    = 0;

  two_channel_timestamp_coincidence dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .channel      (channel),
    .time_tag     (time_tag),
    .event_number (event_number),
    .record_index (record_index),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .pair_time    (pair_time),
    .event_zero   (event_zero),
    .event_one    (event_one),
    .index_zero   (index_zero),
    .index_one    (index_one),
    .lost_channel (lost_channel),
    .drops_so_far (drops_so_far),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one hit, hold it until the transfer, then idle the sender now and then
  task automatic send_hit(input bit ch, input logic [31:0] t, input logic [31:0] ev,
                          input logic [31:0] ix);
    hit_t h;
    h.channel      = ch;
    h.time_tag     = t;
    h.event_number = ev;
    h.record_index = ix;
    push         <= 1'b1;
    channel      <= ch;
    time_tag     <= t;
    event_number <= ev;
    record_index <= ix;
    do @(posedge clk); while (full);
    tracker.accept_hit(h);
    sent++;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Result side: check each transfer, then decide pop for the next edge
  initial begin
    int      stall_left;
    result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.status       = status_t'(status);
        got.pair_time    = pair_time;
        got.event_zero   = event_zero;
        got.event_one    = event_one;
        got.index_zero   = index_zero;
        got.index_one    = index_one;
        got.lost_channel = lost_channel;
        got.drops_so_far = drops_so_far;
        got.last_of_run  = last_of_run;
        tracker.check_record(got);
      end
      if (rx_hold_request) begin
        stall_left      = LONG_HOLD;
        rx_hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stop the run when nothing has moved on either side for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] clock_tag;
    int          pick;
    int          burst;
    bit          first;
    bit          hold_done;
    bit          drain_done;
    tracker    = new();
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: pairs at both time extremes, abandons on each side
    send_hit(CHAN_ZERO, 32'h0, 32'h0, 32'h0);
    send_hit(CHAN_ONE, 32'h0, '1, '1);
    send_hit(CHAN_ONE, '1, '1, 32'h0);
    send_hit(CHAN_ZERO, 32'd5, 32'h0, '1);
    send_hit(CHAN_ZERO, '1, $urandom, $urandom);
    send_hit(CHAN_ZERO, 32'h8000_0000, $urandom, $urandom);
    send_hit(CHAN_ONE, 32'h7fff_ffff, $urandom, $urandom);
    // Fill channel zero, overflow it, then flush it with a late channel one hit
    for (int k = 0; k < 7; k++)
      send_hit(CHAN_ZERO, 32'h8000_0001 + k, $urandom, $urandom);
    send_hit(CHAN_ZERO, 32'h1234, $urandom, $urandom);
    send_hit(CHAN_ONE, '1, $urandom, $urandom);
    // Fill channel one and overflow it
    for (int k = 0; k < 7; k++)
      send_hit(CHAN_ONE, k, $urandom, $urandom);
    send_hit(CHAN_ONE, 32'd9, $urandom, $urandom);

    // Random: mostly coincident pairs on a rising time line, with noise and bursts
    clock_tag = $urandom;
    while (sent < ITEM_TOTAL) begin
      if (!hold_done && sent >= 150) begin
        rx_hold_request = 1'b1;
        hold_done       = 1'b1;
      end
      if (!drain_done && sent >= 260) begin
        push <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge clk);
        drain_done = 1'b1;
      end
      if (sent >= 340) idling_on = 1'b0;
      pick  = $urandom_range(0, 99);
      first = $urandom_range(0, 1);
      if (pick < 55) begin
        send_hit(first, clock_tag, $urandom, $urandom);
        send_hit(!first, clock_tag, $urandom, $urandom);
        clock_tag += $urandom_range(1, 40);
      end else if (pick < 72) begin
        send_hit(first, clock_tag, $urandom, $urandom);
        clock_tag += $urandom_range(1, 40);
      end else if (pick < 82) begin
        // Near miss: partner one tick off either way
        send_hit(first, clock_tag, $urandom, $urandom);
        send_hit(!first, $urandom_range(0, 1) ? clock_tag + 1 : clock_tag - 1,
                 $urandom, $urandom);
        clock_tag += 3;
      end else if (pick < 92) begin
        send_hit(first, $urandom, $urandom, $urandom);
      end else begin
        burst = $urandom_range(6, 11);
        for (int k = 0; k < burst; k++) begin
          send_hit(first, clock_tag, $urandom, $urandom);
          clock_tag += $urandom_range(1, 5);
        end
      end
    end
    push <= 1'b0;

    // Wait for every owed record, then leave room for any stray one
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_front.sv
rtl/core/tcc_back.sv
rtl/core/tcc_out.sv
rtl/core/two_channel_timestamp_coincidence.sv
test/testbench.sv
